// ----- src/upx_pkg.sv -----
// ----------------------------------------------------------------------------
// upx_pkg
// Shared constants, types and helpers of the power-of-two texture upscaler.
// ----------------------------------------------------------------------------
package upx_pkg;

    localparam int MAX_SIDE   = 128;
    localparam int COORD_W    = $clog2(MAX_SIDE);          // 7
    localparam int SIDE_W     = COORD_W + 1;               // 8
    localparam int LOG_W      = 4;
    localparam int FIX_W      = COORD_W + SIDE_W;          // row * side
    localparam int BANK_AW    = 2 * (COORD_W - 1);         // per-bank address
    localparam int WGT_W      = 2 * SIDE_W;
    localparam int PROD_W     = WGT_W + 8;
    localparam int SUM_W      = PROD_W + 2;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE_MODE = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic MODE_NEAREST = 1'b0;

    typedef logic [31:0] upx_pixel_t;   // red in the low byte

    typedef struct packed {
        logic [WGT_W-1:0] wa;
        logic [WGT_W-1:0] wb;
        logic [WGT_W-1:0] wc;
        logic [WGT_W-1:0] wd;
    } upx_wgt_t;

    // clamp a side register to 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] eff_side(input logic [7:0] v);
        logic [SIDE_W-1:0] r;
        if (v == 8'd0)
            r = SIDE_W'(1);
        else if (32'(v) > MAX_SIDE)
            r = SIDE_W'(MAX_SIDE);
        else
            r = SIDE_W'(v);
        return r;
    endfunction

    // smallest l with 2^l >= v
    function automatic logic [LOG_W-1:0] ceil_log2(input logic [SIDE_W-1:0] v);
        logic [LOG_W-1:0] l;
        l = '0;
        for (int i = 0; i < SIDE_W; i++)
        begin
            if ((SIDE_W+1)'(1 << l) < (SIDE_W+1)'(v))
                l = l + 1'b1;
        end
        return l;
    endfunction

endpackage

// ----- src/upx_req_if.sv -----
// ----------------------------------------------------------------------------
// upx_req_if
// Request channel: pixel loads and destination fetches.
// ----------------------------------------------------------------------------
interface upx_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [6:0] row;
    logic [6:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, cmd, row, col, red, green, blue, alpha, input ready);
    modport sink   (input valid, cmd, row, col, red, green, blue, alpha, output ready);
endinterface

// ----- src/upx_rsp_if.sv -----
// ----------------------------------------------------------------------------
// upx_rsp_if
// Response channel: resampled pixels.
// ----------------------------------------------------------------------------
interface upx_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_of_range;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, out_of_range,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_of_range,
                    output ready);
endinterface

// ----- src/upx_bank.sv -----
// ----------------------------------------------------------------------------
// upx_bank
// One parity bank of the source image: one write, one registered read.
// ----------------------------------------------------------------------------
module upx_bank
    import upx_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [BANK_AW-1:0] waddr,
    input  upx_pixel_t         wdata,
    input  logic               re,
    input  logic [BANK_AW-1:0] raddr,
    output upx_pixel_t         rdata
);

    upx_pixel_t mem [2**BANK_AW];
    upx_pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/upx_lane.sv -----
// ----------------------------------------------------------------------------
// upx_lane
// One color channel: four weighted taps, then sum, shift and saturate.
// ----------------------------------------------------------------------------
module upx_lane
    import upx_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  upx_wgt_t         wgt,
    input  logic [7:0]       pa,
    input  logic [7:0]       pb,
    input  logic [7:0]       pc,
    input  logic [7:0]       pd,
    input  logic [LOG_W:0]   shamt,
    output logic [7:0]       res
);

    logic [PROD_W-1:0] ta_reg, tb_reg, tc_reg, td_reg;
    logic [7:0]        res_reg;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  shifted;
    logic [7:0]        res_next;

    always_comb
    begin
        sum      = SUM_W'(ta_reg) + SUM_W'(tb_reg) + SUM_W'(tc_reg) + SUM_W'(td_reg);
        shifted  = sum >> shamt;
        res_next = (shifted > SUM_W'(255)) ? 8'hFF : shifted[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg  <= PROD_W'(wgt.wa) * PROD_W'(pa);
            tb_reg  <= PROD_W'(wgt.wb) * PROD_W'(pb);
            tc_reg  <= PROD_W'(wgt.wc) * PROD_W'(pc);
            td_reg  <= PROD_W'(wgt.wd) * PROD_W'(pd);
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- src/pow2_texture_upscaler.sv -----
// ----------------------------------------------------------------------------
// pow2_texture_upscaler
// Holds an RGBA source image and returns pixels of the power-of-two sized
// destination, resampled by nearest or bilinear filtering.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  req      in   load (cmd 0) or fetch (cmd 1), row, col, rgba
//  rsp      out  out_red..out_alpha, out_of_range; one per fetch
//  cfg      in   cfg_we / cfg_index / cfg_data, write only
//
//  One word per cycle while rsp is not stalled. A fetch passes through the
//  coordinate multiply, bank read + weights, tap multiply and sum/shift
//  registers before it shows on rsp.
//  In-range loads write the bank on the accept edge; loads produce no word.
//  The whole pipeline advances when rsp is empty or being taken; req.ready
//  follows that, so a stalled output holds every stage.
//  Reset clears valids and config; the image store is not cleared.
// ----------------------------------------------------------------------------
module pow2_texture_upscaler
    import upx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    upx_req_if.sink     req,
    upx_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // ---------------- configuration ----------------
    logic [7:0]       src_width_reg, src_height_reg;
    logic             scale_mode_reg;
    logic [LOG_W-1:0] lw_reg, lh_reg;
    logic [7:0]       wr_width_next, wr_height_next;

    always_comb
    begin
        wr_width_next  = src_width_reg;
        wr_height_next = src_height_reg;
        if (cfg_we && cfg_index == REG_SRC_WIDTH)
            wr_width_next = cfg_data;
        if (cfg_we && cfg_index == REG_SRC_HEIGHT)
            wr_height_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 8'd1;
            src_height_reg <= 8'd1;
            scale_mode_reg <= MODE_NEAREST;
            lw_reg         <= '0;
            lh_reg         <= '0;
        end
        else if (cfg_we)
        begin
            src_width_reg  <= wr_width_next;
            src_height_reg <= wr_height_next;
            if (cfg_index == REG_SCALE_MODE)
                scale_mode_reg <= cfg_data[0];
            lw_reg <= ceil_log2(eff_side(wr_width_next));
            lh_reg <= ceil_log2(eff_side(wr_height_next));
        end
    end

    logic [SIDE_W-1:0] w, h, dw, dh;
    logic [LOG_W:0]    shamt;

    assign w     = eff_side(src_width_reg);
    assign h     = eff_side(src_height_reg);
    assign dw    = SIDE_W'(1) << lw_reg;
    assign dh    = SIDE_W'(1) << lh_reg;
    assign shamt = (LOG_W+1)'(lw_reg) + (LOG_W+1)'(lh_reg);

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic oor1_reg, oor2_reg, oor3_reg, oor4_reg;
    logic en;
    logic acc, fetch_acc, load_ok;

    assign en        = !v4_reg || rsp.ready;
    assign req.ready = en;
    assign acc       = req.valid && en;
    assign fetch_acc = acc && req.cmd == CMD_FETCH;
    assign load_ok   = acc && req.cmd == CMD_LOAD
                       && SIDE_W'(req.row) < h && SIDE_W'(req.col) < w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= fetch_acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: fixed-point source position ----------------
    logic [FIX_W-1:0] py1_reg, px1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py1_reg  <= FIX_W'(req.row) * FIX_W'(h);
            px1_reg  <= FIX_W'(req.col) * FIX_W'(w);
            oor1_reg <= SIDE_W'(req.row) >= dh || SIDE_W'(req.col) >= dw;
        end
    end

    // ---------------- stage 2: neighbors, weights, bank reads ----------------
    logic [SIDE_W-1:0]  rr, cc, ra, rb, ca, cb;
    logic [COORD_W-1:0] fy, fx;
    upx_wgt_t           wgt_next, wgt2_reg;
    logic [3:0]         par2_reg;           // {ra0, rb0, ca0, cb0}

    always_comb
    begin
        rr = SIDE_W'((py1_reg + FIX_W'(dh >> 1)) >> lh_reg);
        cc = SIDE_W'((px1_reg + FIX_W'(dw >> 1)) >> lw_reg);
        if (rr >= h)
            rr = h - 1'b1;
        if (cc >= w)
            cc = w - 1'b1;

        if (scale_mode_reg == MODE_NEAREST)
        begin
            // nearest is the blend with zero fraction at the rounded point
            ra = rr;
            ca = cc;
            rb = rr;
            cb = cc;
            fy = '0;
            fx = '0;
        end
        else
        begin
            ra = SIDE_W'(py1_reg >> lh_reg);
            ca = SIDE_W'(px1_reg >> lw_reg);
            fy = COORD_W'(py1_reg & FIX_W'(dh - 1'b1));
            fx = COORD_W'(px1_reg & FIX_W'(dw - 1'b1));
            rb = ra + SIDE_W'(fy != '0);
            cb = ca + SIDE_W'(fx != '0);
            if (rb >= h)
                rb = ra;    // far row past the edge
            if (cb >= w)
                cb = ca;
        end

        wgt_next.wa = WGT_W'(dw - SIDE_W'(fx)) * WGT_W'(dh - SIDE_W'(fy));
        wgt_next.wb = WGT_W'(dw - SIDE_W'(fx)) * WGT_W'(fy);
        wgt_next.wc = WGT_W'(fx) * WGT_W'(dh - SIDE_W'(fy));
        wgt_next.wd = WGT_W'(fx) * WGT_W'(fy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wgt2_reg <= wgt_next;
            par2_reg <= {ra[0], rb[0], ca[0], cb[0]};
            oor2_reg <= oor1_reg;
        end
    end

    // four banks by {row parity, col parity}; each sees one of the rows and
    // one of the columns, so all four neighbors come out in one read
    upx_pixel_t bank_q [4];
    upx_pixel_t load_px;

    assign load_px = {req.alpha, req.blue, req.green, req.red};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BANK_ROW = 1'(b >> 1);
        localparam logic BANK_COL = 1'(b & 1);
        logic [SIDE_W-1:0]  sel_r, sel_c;
        logic [BANK_AW-1:0] raddr, waddr;
        logic               we;

        assign sel_r = (ra[0] == BANK_ROW) ? ra : rb;
        assign sel_c = (ca[0] == BANK_COL) ? ca : cb;
        assign raddr = {sel_r[COORD_W-1:1], sel_c[COORD_W-1:1]};
        assign waddr = {req.row[COORD_W-1:1], req.col[COORD_W-1:1]};
        assign we    = load_ok && req.row[0] == BANK_ROW && req.col[0] == BANK_COL;

        upx_bank u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (load_px),
            .re    (en),
            .raddr (raddr),
            .rdata (bank_q[b])
        );
    end

    // ---------------- stages 3-4: per-channel lanes ----------------
    upx_pixel_t pa, pb, pc, pd;
    logic [7:0] lane_res [4];

    assign pa = bank_q[{par2_reg[3], par2_reg[1]}];
    assign pb = bank_q[{par2_reg[2], par2_reg[1]}];
    assign pc = bank_q[{par2_reg[3], par2_reg[0]}];
    assign pd = bank_q[{par2_reg[2], par2_reg[0]}];

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        upx_lane u_lane (
            .clk   (clk),
            .en    (en),
            .wgt   (wgt2_reg),
            .pa    (pa[8*k +: 8]),
            .pb    (pb[8*k +: 8]),
            .pc    (pc[8*k +: 8]),
            .pd    (pd[8*k +: 8]),
            .shamt (shamt),
            .res   (lane_res[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor3_reg <= oor2_reg;
            oor4_reg <= oor3_reg;
        end
    end

    // merge: out-of-range fetches return a zero pixel
    assign rsp.valid        = v4_reg;
    assign rsp.out_of_range = oor4_reg;
    assign rsp.out_red      = oor4_reg ? 8'd0 : lane_res[0];
    assign rsp.out_green    = oor4_reg ? 8'd0 : lane_res[1];
    assign rsp.out_blue     = oor4_reg ? 8'd0 : lane_res[2];
    assign rsp.out_alpha    = oor4_reg ? 8'd0 : lane_res[3];

endmodule

// ----- src/upx_checker.sv -----
// ----------------------------------------------------------------------------
// upx_checker
// Port-level checks of the texture upscaler.
// ----------------------------------------------------------------------------
module upx_checker
    import upx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_red,
    input logic [7:0] rsp_green,
    input logic [7:0] rsp_blue,
    input logic [7:0] rsp_alpha,
    input logic       rsp_oor
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("word dropped while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_oor |-> rsp_red == 8'd0 && rsp_green == 8'd0
                                 && rsp_blue == 8'd0 && rsp_alpha == 8'd0)
        else $error("out-of-range word carries data");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid || rsp_ready |-> req_ready)
        else $error("input blocked with free output");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("input taken during output stall");

endmodule

bind pow2_texture_upscaler upx_checker u_upx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_red   (rsp.out_red),
    .rsp_green (rsp.out_green),
    .rsp_blue  (rsp.out_blue),
    .rsp_alpha (rsp.out_alpha),
    .rsp_oor   (rsp.out_of_range)
);

// ----- dv/tb_pow2_texture_upscaler.sv -----
// ----------------------------------------------------------------------------
// tb_pow2_texture_upscaler
// Self-checking bench for the texture upscaler. Loads and fetches go out on
// the request channel through a queued driver. A predictor that tracks the
// image store and the size registers works out each fetched pixel, and a
// monitor compares every response word with the oldest expected pixel.
// The run walks through many sizes and both filter modes, with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module tb_pow2_texture_upscaler;
    import upx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;      // pipeline is four deep, plus margin
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic       cmd;
        logic [6:0] row;
        logic [6:0] col;
        upx_pixel_t rgba;                 // red in the low byte
    } req_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       oor;
    } pixel_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    upx_req_if req_if();
    upx_rsp_if rsp_if();

    pow2_texture_upscaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the image store and the registers.
    // written[] marks entries loaded so far; fetches never touch others.
    // ------------------------------------------------------------------
    upx_pixel_t image_shadow [MAX_SIDE*MAX_SIDE];
    bit         written      [MAX_SIDE*MAX_SIDE];
    logic [7:0] width_reg  = 8'd1;
    logic [7:0] height_reg = 8'd1;
    logic       mode_reg   = MODE_NEAREST;

    req_word_t  pending_words[$];
    pixel_out_t expected_pixels[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;

    // register value as the block sees it: 0 acts as 1, above MAX_SIDE clamps
    function automatic int side_of(logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (int'(v) > MAX_SIDE)
            return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic int log2_up(int v);
        int l;
        l = 0;
        while ((1 << l) < v)
            l++;
        return l;
    endfunction

    // source rows/cols touched by an in-range fetch (near and far taps)
    function automatic void fetch_taps(input int row, input int col,
                                       output int r0, output int r1,
                                       output int c0, output int c1);
        int w, h, lw, lh, py, px;
        w  = side_of(width_reg);
        h  = side_of(height_reg);
        lw = log2_up(w);
        lh = log2_up(h);
        py = row * h;
        px = col * w;
        if (mode_reg == MODE_NEAREST)
        begin
            // round half up, kept below the source side
            r0 = (py + ((1 << lh) >> 1)) >> lh;
            c0 = (px + ((1 << lw) >> 1)) >> lw;
            if (r0 >= h) r0 = h - 1;
            if (c0 >= w) c0 = w - 1;
            r1 = r0;
            c1 = c0;
        end
        else
        begin
            r0 = py >> lh;
            c0 = px >> lw;
            r1 = r0 + (((py & ((1 << lh) - 1)) != 0) ? 1 : 0);
            c1 = c0 + (((px & ((1 << lw) - 1)) != 0) ? 1 : 0);
            // far tap past the edge falls back to the near one
            if (r1 >= h) r1 = r0;
            if (c1 >= w) c1 = c0;
        end
    endfunction

    function automatic pixel_out_t resample(int row, int col);
        pixel_out_t res;
        int w, h, lw, lh, dw, dh, fy, fx, r0, r1, c0, c1;
        longint wa, wb, wc, wd, v;
        upx_pixel_t pa, pb, pc, pd;
        w  = side_of(width_reg);
        h  = side_of(height_reg);
        lw = log2_up(w);
        lh = log2_up(h);
        dw = 1 << lw;
        dh = 1 << lh;
        res = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
        if (row >= dh || col >= dw)
        begin
            res.oor = 1'b1;
            return res;
        end
        fetch_taps(row, col, r0, r1, c0, c1);
        pa = image_shadow[r0*MAX_SIDE + c0];
        pb = image_shadow[r1*MAX_SIDE + c0];
        pc = image_shadow[r0*MAX_SIDE + c1];
        pd = image_shadow[r1*MAX_SIDE + c1];
        if (mode_reg == MODE_NEAREST)
        begin
            {res.alpha, res.blue, res.green, res.red} = pa;
            return res;
        end
        fy = (row * h) & (dh - 1);
        fx = (col * w) & (dw - 1);
        wa = longint'(dw - fx) * (dh - fy);
        wb = longint'(dw - fx) * fy;
        wc = longint'(fx) * (dh - fy);
        wd = longint'(fx) * fy;
        for (int ch = 0; ch < 4; ch++)
        begin
            v = wa * pa[ch*8 +: 8] + wb * pb[ch*8 +: 8]
              + wc * pc[ch*8 +: 8] + wd * pd[ch*8 +: 8];
            v = v >> (lw + lh);
            if (v > 255) v = 255;
            case (ch)
                0: res.red   = v[7:0];
                1: res.green = v[7:0];
                2: res.blue  = v[7:0];
                default: res.alpha = v[7:0];
            endcase
        end
        return res;
    endfunction

    // queue a load; the shadow is updated now since words apply in order.
    // Row and col are cut to the 7-bit port width, as the block sees them.
    task automatic push_load(int row, int col, upx_pixel_t rgba);
        req_word_t wd;
        row = row & 127;
        col = col & 127;
        wd = '{CMD_LOAD, 7'(row), 7'(col), rgba};
        if (row < side_of(height_reg) && col < side_of(width_reg))
        begin
            image_shadow[row*MAX_SIDE + col] = rgba;
            written[row*MAX_SIDE + col] = 1'b1;
        end
        pending_words.push_back(wd);
    endtask

    // queue a fetch, first loading any tap that was never written
    task automatic push_fetch(int row, int col);
        req_word_t wd;
        int r0, r1, c0, c1, dw, dh;
        int rs[4];
        int cs[4];
        dw = 1 << log2_up(side_of(width_reg));
        dh = 1 << log2_up(side_of(height_reg));
        if (row < dh && col < dw)
        begin
            fetch_taps(row, col, r0, r1, c0, c1);
            rs = '{r0, r1, r0, r1};
            cs = '{c0, c0, c1, c1};
            for (int i = 0; i < 4; i++)
                if (!written[rs[i]*MAX_SIDE + cs[i]])
                    push_load(rs[i], cs[i], $urandom);
        end
        expected_pixels.push_back(resample(row, col));
        wd = '{CMD_FETCH, 7'(row), 7'(col), $urandom};
        pending_words.push_back(wd);
    endtask

    // ------------------------------------------------------------------
    // Driver: one word per accept, random idle cycles between words.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!req_if.valid || req_if.ready))
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_word_t wd;
                wd = pending_words.pop_front();
                req_if.valid <= 1'b1;
                req_if.cmd   <= wd.cmd;
                req_if.row   <= wd.row;
                req_if.col   <= wd.col;
                {req_if.alpha, req_if.blue, req_if.green, req_if.red} <= wd.rgba;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken response word, then pick next ready.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d words pending, %0d pixels expected",
                     $realtime, pending_words.size(), expected_pixels.size());
            $display("tb_pow2_texture_upscaler NOT OK");
            $finish;
        end
        else if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                pixel_out_t got;
                pixel_out_t exp_px;
                got = '{rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue,
                        rsp_if.out_alpha, rsp_if.out_of_range};
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: actual rgba %h %h %h %h oor %b",
                             $realtime, got.red, got.green, got.blue, got.alpha,
                             got.oor);
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (got != exp_px)
                    begin
                        errors++;
                        $display("%0t mismatch: expected rgba %h %h %h %h oor %b, %s%h %h %h %h oor %b",
                                 $realtime, exp_px.red, exp_px.green, exp_px.blue,
                                 exp_px.alpha, exp_px.oor, "actual rgba ",
                                 got.red, got.green, got.blue, got.alpha, got.oor);
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // wait until the block has nothing in flight
    task automatic wait_idle();
        while (pending_words.size() > 0 || expected_pixels.size() > 0 || req_if.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SRC_WIDTH:  width_reg  = val;
            REG_SRC_HEIGHT: height_reg = val;
            default:        mode_reg   = val[0];
        endcase
    endtask

    // phase table: raw width, raw height, mode (0 and 255 test side clamping)
    int phase_w[12]    = '{1, 0, 3, 5, 128, 255, 7, 100, 2, 17, 128, 1};
    int phase_h[12]    = '{1, 0, 5, 3, 128, 200, 100, 7, 2, 33, 1, 128};
    int phase_mode[12] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 1, 0, 1};

    initial
    begin
        int w, h, dw, dh, pick;
        req_if.valid = 1'b0;
        req_if.cmd   = CMD_LOAD;
        req_if.row   = '0;
        req_if.col   = '0;
        req_if.red   = '0;
        req_if.green = '0;
        req_if.blue  = '0;
        req_if.alpha = '0;
        rsp_if.ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            write_reg(REG_SRC_WIDTH,  8'(phase_w[ph]));
            write_reg(REG_SRC_HEIGHT, 8'(phase_h[ph]));
            write_reg(REG_SCALE_MODE, 8'(phase_mode[ph]));
            @(posedge clk);
            cfg_we <= 1'b0;

            w  = side_of(width_reg);
            h  = side_of(height_reg);
            dw = 1 << log2_up(w);
            dh = 1 << log2_up(h);

            // directed: black and white corners, far corners, edges, the centre,
            // dropped loads and fetches past the destination
            push_load(0, 0, 32'h0000_0000);
            push_load(h - 1, w - 1, 32'hFFFF_FFFF);
            push_load(0, w - 1, 32'hFF00_FF00);
            push_load(h - 1, 0, 32'h00FF_00FF);
            push_load(127, 127, 32'hDEAD_BEEF);   // dropped unless 128x128
            push_load(h, 0, 32'h1234_5678);       // dropped when h < 128
            push_fetch(0, 0);
            push_fetch(dh - 1, dw - 1);
            push_fetch(0, dw - 1);
            push_fetch(dh - 1, 0);
            push_fetch(dh / 2, dw / 2);
            push_fetch(127, 127);
            push_fetch(dh % 128, 0);
            push_fetch(0, dw % 128);

            for (int n = 0; n < 30; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                    push_fetch($urandom_range(dh - 1), $urandom_range(dw - 1));
                else if (pick < 82)
                    push_load($urandom_range(h - 1), $urandom_range(w - 1), $urandom);
                else if (pick < 91)
                    push_fetch($urandom_range(127), $urandom_range(127));
                else
                    push_load($urandom_range(127), $urandom_range(127), $urandom);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb_pow2_texture_upscaler OK");
        else
            $display("tb_pow2_texture_upscaler NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
src/upx_pkg.sv
src/upx_req_if.sv
src/upx_rsp_if.sv
src/upx_bank.sv
src/upx_lane.sv
src/pow2_texture_upscaler.sv
src/upx_checker.sv
dv/tb_pow2_texture_upscaler.sv
